// ----- hw/rtl/fba_pkg.sv -----
`default_nettype none

package fba_pkg;

  // table geometry
  localparam int unsigned BLOCKS    = 16;
  localparam int unsigned SIZE_BITS = 16;
  localparam int unsigned IDX_W     = $clog2(BLOCKS);
  localparam int unsigned CNT_W     = $clog2(BLOCKS + 1);
  localparam int unsigned WASTE_W   = 20;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned POL_W     = 2;
  localparam int unsigned CFG_W     = 5;

  localparam logic [CNT_W-1:0]   BLOCKS_CNT = CNT_W'(BLOCKS);
  localparam logic [WASTE_W-1:0] WASTE_MAX  = {WASTE_W{1'b1}};

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // fit policy codes, anything else acts as first fit
  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  // configuration register indexes
  localparam logic REG_FIT_POLICY  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } fba_state_e;

  typedef struct packed {
    logic capture;
    logic step;
    logic finish;
  } fba_cmd_t;

  typedef struct packed {
    logic scan_done;
  } fba_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fba_ctrl.sv -----
`default_nettype none

module fba_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire fba_pkg::fba_stat_t stat_i,
  output fba_pkg::fba_cmd_t     cmd_o
);
  import fba_pkg::*;

  fba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.scan_done) state_d = ST_FINISH;
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd_o.capture = start;
      end
      ST_SCAN:   cmd_o.step   = !stat_i.scan_done;
      ST_FINISH: cmd_o.finish = 1'b1;
      default:   busy = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fba_datapath.sv -----
`default_nettype none

module fba_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fba_pkg::fba_cmd_t             cmd_i,
  output fba_pkg::fba_stat_t                 stat_o,
  input  wire logic [fba_pkg::POL_W-1:0]     fit_policy_i,
  input  wire logic [fba_pkg::CNT_W-1:0]     block_count_i,
  input  wire logic [fba_pkg::OP_W-1:0]      operation_i,
  input  wire logic [fba_pkg::IDX_W-1:0]     block_slot_i,
  input  wire logic [fba_pkg::SIZE_BITS-1:0] amount_i,
  output logic                               result_valid_o,
  output logic                               granted_o,
  output logic [fba_pkg::IDX_W-1:0]          chosen_block_o,
  output logic [fba_pkg::SIZE_BITS-1:0]      chosen_size_o,
  output logic [fba_pkg::SIZE_BITS-1:0]      leftover_o,
  output logic [fba_pkg::WASTE_W-1:0]        waste_total_o
);
  import fba_pkg::*;

  // block table and marks
  logic [SIZE_BITS-1:0] size_q [BLOCKS];
  logic [BLOCKS-1:0]    in_use_q, in_use_d;
  logic [WASTE_W-1:0]   waste_q, waste_d;

  // captured request
  logic [OP_W-1:0]      op_q;
  logic [IDX_W-1:0]     slot_q;
  logic [SIZE_BITS-1:0] amt_q;

  // scan state
  logic [CNT_W-1:0]     idx_q;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     pick_q, pick_d;
  logic [SIZE_BITS-1:0] pick_size_q, pick_size_d;

  logic [CNT_W-1:0]     limit;
  logic [IDX_W-1:0]     cur;
  logic [IDX_W-1:0]     rd_idx;
  logic [SIZE_BITS-1:0] cur_size_q;
  logic [SIZE_BITS-1:0] cur_size;
  logic                 cand;
  logic                 best_fit, worst_fit;
  logic [SIZE_BITS-1:0] left;
  logic [WASTE_W:0]     sum;

  logic                 res_valid_q;
  logic                 granted_q;
  logic [IDX_W-1:0]     chosen_q;
  logic [SIZE_BITS-1:0] csize_q, left_q;
  logic [WASTE_W-1:0]   wtotal_q;

  assign best_fit  = (fit_policy_i == POL_BEST);
  assign worst_fit = (fit_policy_i == POL_WORST);
  assign limit     = (block_count_i > BLOCKS_CNT) ? BLOCKS_CNT : block_count_i;

  assign cur      = idx_q[IDX_W-1:0];
  // table read is registered, so fetch the entry the scan index moves to
  assign rd_idx   = cmd_i.capture ? '0 :
                    (cmd_i.step ? IDX_W'(idx_q + CNT_W'(1)) : cur);
  assign cur_size = cur_size_q;
  assign cand     = !in_use_q[cur] && (cur_size >= amt_q);

  // first fit stops at the first hit
  assign stat_o.scan_done = (op_q != OP_ALLOC) || (idx_q >= limit) ||
                            (found_q && !best_fit && !worst_fit);

  always_comb begin
    found_d     = found_q;
    pick_d      = pick_q;
    pick_size_d = pick_size_q;
    if (cand) begin
      if (!found_q) begin
        found_d     = 1'b1;
        pick_d      = cur;
        pick_size_d = cur_size;
      end else if ((best_fit && (cur_size < pick_size_q)) ||
                   (worst_fit && (cur_size > pick_size_q))) begin
        pick_d      = cur;
        pick_size_d = cur_size;
      end
    end
  end

  assign left = pick_size_q - amt_q;
  assign sum  = {1'b0, waste_q} + (WASTE_W + 1)'(left);

  always_comb begin
    in_use_d = in_use_q;
    waste_d  = waste_q;
    case (op_q)
      OP_LOAD:  in_use_d[slot_q] = 1'b0;
      OP_ALLOC: begin
        if (found_q) begin
          in_use_d[pick_q] = 1'b1;
          waste_d = sum[WASTE_W] ? WASTE_MAX : sum[WASTE_W-1:0];
        end
      end
      OP_CLEAR: begin
        in_use_d = '0;
        waste_d  = '0;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= '0;
      waste_q     <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.finish;
      if (cmd_i.capture) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.step) begin
        idx_q   <= idx_q + CNT_W'(1);
        found_q <= found_d;
      end
      if (cmd_i.finish) begin
        in_use_q <= in_use_d;
        waste_q  <= waste_d;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cur_size_q <= size_q[rd_idx];
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      slot_q <= block_slot_i;
      amt_q  <= amount_i;
    end
    if (cmd_i.step) begin
      pick_q      <= pick_d;
      pick_size_q <= pick_size_d;
    end
    if (cmd_i.finish) begin
      if (op_q == OP_LOAD) size_q[slot_q] <= amt_q;
      if ((op_q == OP_ALLOC) && found_q) begin
        granted_q <= 1'b1;
        chosen_q  <= pick_q;
        csize_q   <= pick_size_q;
        left_q    <= left;
      end else begin
        granted_q <= 1'b0;
        chosen_q  <= '0;
        csize_q   <= '0;
        left_q    <= '0;
      end
      wtotal_q <= waste_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign granted_o      = granted_q;
  assign chosen_block_o = chosen_q;
  assign chosen_size_o  = csize_q;
  assign leftover_o     = left_q;
  assign waste_total_o  = wtotal_q;

endmodule

`default_nettype wire

// ----- hw/rtl/fit_policy_block_allocator.sv -----
`default_nettype none

// fixed-partition block allocator with first, best or worst fit
//
// command channel: operation_i, block_slot_i and amount_i are taken as one
// beat at a rising edge where start is high and busy is low. busy stays
// high while the beat is worked on.
// result channel: every beat gives exactly one result; result_valid_o is
// high for one cycle with granted_o, chosen_block_o, chosen_size_o,
// leftover_o and waste_total_o. the receiver cannot stall, so the result
// is simply taken at the edge that ends that cycle.
// flow: a load, clear or unknown operation examines no entries in the
// scan state and goes on to the finish state, which registers the result.
// an allocate scans one table entry per cycle through a single compare
// unit, up to block_count entries (at most 16; first fit stops at the
// first hit). a new beat can be taken in the cycle its result shows.
// config: cfg_we_i, cfg_index_i (0 fit policy, 1 block count), cfg_data_i,
// to be written only while idle, which the block itself does not enforce.
// reset clears the marks, the waste total, both config registers and the
// controller; block sizes are undefined until loaded.
module fit_policy_block_allocator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [fba_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [fba_pkg::OP_W-1:0]      operation_i,
  input  wire logic [fba_pkg::IDX_W-1:0]     block_slot_i,
  input  wire logic [fba_pkg::SIZE_BITS-1:0] amount_i,
  output logic                               result_valid_o,
  output logic                               granted_o,
  output logic [fba_pkg::IDX_W-1:0]          chosen_block_o,
  output logic [fba_pkg::SIZE_BITS-1:0]      chosen_size_o,
  output logic [fba_pkg::SIZE_BITS-1:0]      leftover_o,
  output logic [fba_pkg::WASTE_W-1:0]        waste_total_o
);
  import fba_pkg::*;

  // configuration registers
  logic [POL_W-1:0] fit_policy_q;
  logic [CNT_W-1:0] block_count_q;

  fba_cmd_t  cmd;
  fba_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q  <= POL_FIRST;
      block_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FIT_POLICY:  fit_policy_q  <= cfg_data_i[POL_W-1:0];
        REG_BLOCK_COUNT: block_count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencing: idle, scan, finish
  fba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // table, scan unit, waste total and result registers
  fba_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .fit_policy_i   (fit_policy_q),
    .block_count_i  (block_count_q),
    .operation_i    (operation_i),
    .block_slot_i   (block_slot_i),
    .amount_i       (amount_i),
    .result_valid_o (result_valid_o),
    .granted_o      (granted_o),
    .chosen_block_o (chosen_block_o),
    .chosen_size_o  (chosen_size_o),
    .leftover_o     (leftover_o),
    .waste_total_o  (waste_total_o)
  );

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import fba_pkg::*;

  // codes the package leaves unnamed: the spare operation and the spare policy
  localparam logic [OP_W-1:0]  OP_UNKNOWN = 2'd3;
  localparam logic [POL_W-1:0] POL_SPARE  = 2'd3;

  // run length guard, far above the slowest legal run
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_BEATS  = 150;
  localparam int DRAIN_LIMIT  = 2000;

  // one result beat as the block reports it
  typedef struct packed {
    logic                 granted;
    logic [IDX_W-1:0]     block;
    logic [SIZE_BITS-1:0] size;
    logic [SIZE_BITS-1:0] left;
    logic [WASTE_W-1:0]   total;
  } alloc_result_t;

  // allocator shadow: table, marks, waste sum and registers, plus the
  // queue of results still owed by the block
  class alloc_scoreboard;
    logic [SIZE_BITS-1:0] sizes [BLOCKS];
    bit                   marked [BLOCKS];
    logic [WASTE_W-1:0]   waste;
    logic [POL_W-1:0]     policy;
    logic [CFG_W-1:0]     count;
    alloc_result_t        owed_q [$];
    int                   errors;

    function new();
      foreach (sizes[i]) begin
        sizes[i]  = '0;
        marked[i] = 1'b0;
      end
      waste  = '0;
      policy = POL_FIRST;
      count  = '0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] data);
      if (idx == REG_FIT_POLICY) begin
        policy = data[POL_W-1:0];
      end else begin
        count = data;
      end
    endfunction

    function int eff_count();
      return (count > BLOCKS) ? BLOCKS : int'(count);
    endfunction

    // work out the result of one accepted command beat
    function void note_command(logic [OP_W-1:0] op, logic [IDX_W-1:0] slot,
                               logic [SIZE_BITS-1:0] amt);
      alloc_result_t r;
      int            limit;
      bit            found;
      bit            stop;
      int            pick;
      logic [WASTE_W:0] sum;
      r     = '0;
      found = 1'b0;
      stop  = 1'b0;
      pick  = 0;
      case (op)
        OP_LOAD: begin
          sizes[slot]  = amt;
          marked[slot] = 1'b0;
        end
        OP_ALLOC: begin
          limit = eff_count();
          for (int j = 0; j < limit; j++) begin
            if (!stop && !marked[j] && sizes[j] >= amt) begin
              if (!found) begin
                found = 1'b1;
                pick  = j;
                // first fit, and the spare policy, take the first hit
                stop  = (policy != POL_BEST) && (policy != POL_WORST);
              end else if (policy == POL_BEST && sizes[j] < sizes[pick]) begin
                pick = j;
              end else if (policy == POL_WORST && sizes[j] > sizes[pick]) begin
                pick = j;
              end
            end
          end
          if (found) begin
            marked[pick] = 1'b1;
            r.granted = 1'b1;
            r.block   = IDX_W'(pick);
            r.size    = sizes[pick];
            r.left    = sizes[pick] - amt;
            sum       = waste + r.left;
            waste     = (sum > WASTE_MAX) ? WASTE_MAX : sum[WASTE_W-1:0];
          end
        end
        OP_CLEAR: begin
          foreach (marked[i]) marked[i] = 1'b0;
          waste = '0;
        end
        default: ;
      endcase
      r.total = waste;
      owed_q.push_back(r);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("ERROR at %0t: %s", $time, what);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(logic g, logic [IDX_W-1:0] b, logic [SIZE_BITS-1:0] s,
                      logic [SIZE_BITS-1:0] l, logic [WASTE_W-1:0] t);
      alloc_result_t e;
      if (owed_q.size() == 0) begin
        report($sformatf("result beat with none owed: granted %0b block %0d", g, b));
        return;
      end
      e = owed_q.pop_front();
      compare_field("granted", g, e.granted);
      compare_field("chosen_block", b, e.block);
      compare_field("chosen_size", s, e.size);
      compare_field("leftover", l, e.left);
      compare_field("waste_total", t, e.total);
    endtask
  endclass

  // clock, reset and block pins; the driven ones are all known from time zero
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic                 cfg_index_i  = 1'b0;
  logic [CFG_W-1:0]     cfg_data_i   = '0;
  logic                 start        = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      operation_i  = '0;
  logic [IDX_W-1:0]     block_slot_i = '0;
  logic [SIZE_BITS-1:0] amount_i     = '0;
  logic                 result_valid_o;
  logic                 granted_o;
  logic [IDX_W-1:0]     chosen_block_o;
  logic [SIZE_BITS-1:0] chosen_size_o;
  logic [SIZE_BITS-1:0] leftover_o;
  logic [WASTE_W-1:0]   waste_total_o;

  alloc_scoreboard sb = new();
  int cycle_count = 0;
  int burst_left  = 1;
  int beats_sent  = 0;

  fit_policy_block_allocator DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .block_slot_i   (block_slot_i),
    .amount_i       (amount_i),
    .result_valid_o (result_valid_o),
    .granted_o      (granted_o),
    .chosen_block_o (chosen_block_o),
    .chosen_size_o  (chosen_size_o),
    .leftover_o     (leftover_o),
    .waste_total_o  (waste_total_o)
  );

  always #5 clk_i = ~clk_i;

  // timeout guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result monitor: the strobe lasts one cycle and cannot be held off,
  // so every strobed cycle is a result beat taken at its closing edge
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1)
      sb.check_result(granted_o, chosen_block_o, chosen_size_o, leftover_o, waste_total_o);
  end

  // mostly short bursts, now and then a long stretch without gaps
  function automatic int next_burst();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
  endfunction

  // request sizes: mostly ones that fit some block, with exact fits,
  // one-over misses and the field extremes mixed in
  function automatic logic [SIZE_BITS-1:0] pick_amount();
    logic [SIZE_BITS-1:0] r;
    r = sb.sizes[$urandom_range(0, BLOCKS - 1)];
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return 16'($urandom);
      8:       return r;
      9:       return r + 16'd1;
      default: return 16'($urandom_range(0, r));
    endcase
  endfunction

  function automatic logic [SIZE_BITS-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // drive one command beat and hold it until the edge that accepts it;
  // start stays high on return unless the burst has run out
  task automatic issue(logic [OP_W-1:0] op, logic [IDX_W-1:0] slot,
                       logic [SIZE_BITS-1:0] amt);
    operation_i  <= op;
    block_slot_i <= slot;
    amount_i     <= amt;
    start        <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_command(op, slot, amt);
    beats_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk_i);
      burst_left = next_burst();
    end
  endtask

  // stop sending and let every owed result come back
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    burst_left = next_burst();
  endtask

  // write both registers on back-to-back edges, only while idle
  task automatic set_regs(logic [CFG_W-1:0] pol_data, logic [CFG_W-1:0] cnt_data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_FIT_POLICY;
    cfg_data_i  <= pol_data;
    @(posedge clk_i);
    sb.write_reg(REG_FIT_POLICY, pol_data);
    cfg_index_i <= REG_BLOCK_COUNT;
    cfg_data_i  <= cnt_data;
    @(posedge clk_i);
    sb.write_reg(REG_BLOCK_COUNT, cnt_data);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [SIZE_BITS-1:0] preset [BLOCKS];
    int                   cnt_plan [12];
    int                   phase_start;
    int                   eff;
    int                   drain;
    logic [IDX_W-1:0]     s;

    preset = '{16'd100, 16'hFFFF, 16'd0, 16'd300, 16'd100, 16'd50, 16'hFFFF, 16'd200,
               16'd1, 16'h8000, 16'd7, 16'd1000, 16'd100, 16'h0FFF, 16'd12345, 16'hFFFE};
    // block counts per random phase: full, none, one, above range, and a mix
    cnt_plan = '{16, 0, 1, 31, 9, 16, 2, 17, 15, 16, 4, 16};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = next_burst();

    // directed: fill the whole table first so no scan ever meets an unloaded block
    set_regs({3'b000, POL_FIRST}, 5'd16);
    for (int i = 0; i < BLOCKS; i++) issue(OP_LOAD, IDX_W'(i), preset[i]);
    // first fit: zero request, full-size requests until none fits
    issue(OP_ALLOC, 4'd9, 16'd0);
    issue(OP_ALLOC, 4'd0, 16'hFFFF);
    issue(OP_ALLOC, 4'd15, 16'hFFFF);
    issue(OP_ALLOC, 4'd0, 16'hFFFF);
    // spare operation leaves everything alone, then clear
    issue(OP_UNKNOWN, 4'd15, 16'hFFFF);
    issue(OP_CLEAR, 4'd5, 16'h5A5A);
    // best fit: three equal blocks of 100, lowest index first; then the empty block
    wait_idle();
    set_regs({3'b000, POL_BEST}, 5'd16);
    issue(OP_ALLOC, 4'd0, 16'd100);
    issue(OP_ALLOC, 4'd0, 16'd100);
    issue(OP_ALLOC, 4'd0, 16'd0);
    // worst fit with upper policy bits set: tie between two full-size blocks
    wait_idle();
    set_regs({3'b111, POL_WORST}, 5'd16);
    issue(OP_ALLOC, 4'd3, 16'd1);
    issue(OP_ALLOC, 4'd3, 16'd1);
    // spare policy acts as first fit, count above the table size
    wait_idle();
    set_regs({3'b000, POL_SPARE}, 5'd31);
    issue(OP_ALLOC, 4'd12, 16'd40000);
    // no blocks taking part: always refused
    wait_idle();
    set_regs({3'b010, POL_FIRST}, 5'd0);
    issue(OP_ALLOC, 4'd0, 16'd0);

    // random phases, each under its own register setting
    for (int p = 0; p < 12; p++) begin
      wait_idle();
      set_regs({3'($urandom), 2'(p % 4)}, 5'(cnt_plan[p]));
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        eff = sb.eff_count();
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: begin
            repeat ($urandom_range(1, 8)) issue(OP_ALLOC, 4'($urandom), pick_amount());
          end
          9, 10, 11, 12: begin
            repeat ($urandom_range(1, 4)) issue(OP_LOAD, 4'($urandom), pick_size());
            repeat ($urandom_range(1, 4)) issue(OP_ALLOC, 4'($urandom), pick_amount());
          end
          13, 14: begin
            // reload big blocks and grab them with tiny requests to push
            // the waste sum into saturation
            repeat (8) begin
              s = (eff > 0) ? 4'($urandom_range(0, eff - 1)) : 4'($urandom);
              issue(OP_LOAD, s, 16'hFF00 | 16'($urandom_range(0, 255)));
              issue(OP_ALLOC, 4'($urandom), 16'($urandom_range(0, 255)));
            end
          end
          15, 16: begin
            // run the table dry so the tail requests find no free block
            repeat ($urandom_range(8, 18))
              issue(OP_ALLOC, 4'($urandom), 16'($urandom_range(0, 15)));
          end
          17, 18: begin
            repeat ($urandom_range(1, 3)) issue(OP_UNKNOWN, 4'($urandom), 16'($urandom));
          end
          default: issue(OP_CLEAR, 4'($urandom), 16'($urandom));
        endcase
      end
    end

    // drain, with its own bound, then the verdict
    start <= 1'b0;
    drain = 0;
    while (sb.owed_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (25) @(posedge clk_i);
    if (sb.owed_q.size() != 0)
      sb.report($sformatf("%0d result beats never arrived", sb.owed_q.size()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/fba_pkg.sv
hw/rtl/fba_ctrl.sv
hw/rtl/fba_datapath.sv
hw/rtl/fit_policy_block_allocator.sv
verif/tb_top.sv
